>>> src/score_map_local_maxima_3x3_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 local maxima block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCORE_MAP_LOCAL_MAXIMA_3X3_DEFINES_SVH
`define SCORE_MAP_LOCAL_MAXIMA_3X3_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication under synchronous reset.
`define SMLM3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smlm3 check failed");
// Next-cycle implication under synchronous reset.
`define SMLM3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smlm3 check failed");
`else
`define SMLM3_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMLM3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/smlm3_pkg.sv
// ----------------------------------------------------------------------------
// smlm3_pkg
// Types, constants and the window peak test of the 3x3 local maxima block.
// ----------------------------------------------------------------------------
package smlm3_pkg;

  localparam int POSX_W    = 10;
  localparam int POSY_W    = 12;
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int N_RES     = 5;

  localparam logic [HREG_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [WREG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [HREG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 2'd2;

  // Result slots in the order they leave the block.
  localparam int SLOT_CENTER = 0;
  localparam int SLOT_RIGHT  = 1;
  localparam int SLOT_BOTTOM = 2;
  localparam int SLOT_CORNER = 3;
  localparam int SLOT_END    = 4;

  typedef logic signed [31:0] score_t;

  typedef score_t win_t [3][3];

  typedef struct packed {
    logic [POSX_W-1:0] pos_x;
    logic [POSY_W-1:0] pos_y;
    score_t            peak_score;
    logic              frame_end;
  } rec_t;

  // True when the value at (cr, cc) beats every in-bounds neighbor of rows
  // rlo..2 and columns clo..2, and beats the threshold. Ties lose.
  function automatic logic peak_at(win_t w, int cr, int cc, int rlo, int clo, score_t thr);
    logic ok;
    int   r;
    int   c;
    ok = (w[cr][cc] > thr);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r >= rlo && c >= clo && !(r == cr && c == cc)) begin
          ok = ok & (w[cr][cc] > w[r][c]);
        end
      end
    end
    return ok;
  endfunction

endpackage

>>> src/smlm3_ifs.sv
// ----------------------------------------------------------------------------
// smlm3 channel interfaces
// Valid/ready channels for score beats in and result beats out.
// ----------------------------------------------------------------------------
interface smlm3_in_if
  import smlm3_pkg::*;
;
  logic   valid;
  logic   ready;
  score_t score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

interface smlm3_out_if
  import smlm3_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [POSX_W-1:0] pos_x;
  logic [POSY_W-1:0] pos_y;
  score_t            peak_score;
  logic              frame_end;

  modport source (output valid, output pos_x, output pos_y, output peak_score,
                  output frame_end, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input peak_score,
                  input frame_end, output ready);
endinterface

>>> src/smlm3_ram.sv
// ----------------------------------------------------------------------------
// smlm3_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module smlm3_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/score_map_local_maxima_3x3.sv
// ----------------------------------------------------------------------------
// score_map_local_maxima_3x3
// Streams a score map in raster order and reports strict 3x3 local maxima
// above a threshold, followed by an end-of-frame record.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents                           Handshake
//  in_ch     in   score (Q16.16)                          valid/ready
//  out_ch    out  pos_x, pos_y, peak_score, frame_end     valid/ready
//  cfg_*     in   index, data (width/height/threshold)    write enable only
//
// A beat with no result does not hold off the next input beat; one with k
// results holds it off until the last of them leaves the single result
// buffer, which drains one record per cycle to a free output register. The
// two row lines live in one RAM, read at accept and written back in the cycle
// after, forwarded when consecutive beats hit the same column. Reset loads the
// configuration and clears the counters and the handshake state; the RAM needs
// no clearing pass. A stalled output keeps input flowing until a result is due.
// ----------------------------------------------------------------------------
`include "score_map_local_maxima_3x3_defines.svh"

module score_map_local_maxima_3x3
  import smlm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int SCORE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  smlm3_in_if.sink             in_ch,
  smlm3_out_if.source          out_ch
);

  localparam int SB    = (SCORE_BITS > 32) ? 32 : SCORE_BITS;
  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int EW    = ($clog2(MAX_WIDTH + 1) > WREG_W) ? $clog2(MAX_WIDTH + 1) : WREG_W;

  // Configuration.
  logic [WREG_W-1:0] frame_width_r;
  logic [HREG_W-1:0] frame_height_r;
  score_t            thr_r;

  // Raster position of the next beat.
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [POSY_W-1:0] row_r, row_nxt;

  // Accept stage.
  logic [EW-1:0]     fw_ext, w_eff;
  logic [HREG_W-1:0] h_eff;
  logic              in_range, last_col, last_row, big, in_acc, in_ready;
  logic [CNT_W-1:0]  x_cur;
  logic [POSY_W-1:0] y_cur;

  // Window stage.
  logic              s1_valid_r;
  logic [CNT_W-1:0]  s1_x_r;
  logic [POSY_W-1:0] s1_y_r;
  score_t            s1_score_r;
  logic              s1_last_col_r, s1_last_row_r, s1_big_r, s1_end_r;

  logic [2*SB-1:0]   ram_rdata, rd_word, wdata, fwd_data_r;
  logic              fwd_r;
  score_t            rd_a, rd_b;
  win_t              win_r, win_nxt;
  logic [CNT_W-1:0]  xm1;
  logic [POSY_W-1:0] ym1;
  int                rlo, clo;
  logic [N_RES-1:0]  res_mask;
  rec_t              res [N_RES];

  // Result buffer and output register.
  logic [N_RES-1:0]  b_mask_r, b_mask_nxt, b_pick;
  rec_t              b_rec_r [N_RES];
  rec_t              b_sel;
  logic              b_load, b_move;
  logic              out_valid_r;
  rec_t              out_rec_r;

  // ---------------------------------------------------------------- geometry
  always_comb begin
    fw_ext = EW'(frame_width_r);
    if (fw_ext == '0) begin
      w_eff = EW'(1);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height_r == '0) begin
      h_eff = HREG_W'(1);
    end else if (frame_height_r > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = frame_height_r;
    end
  end

  // ------------------------------------------------------------ accept stage
  always_comb begin
    in_range = (EW'(col_r) < w_eff) && (HREG_W'(row_r) < h_eff);
    x_cur    = in_range ? col_r : '0;
    y_cur    = in_range ? row_r : '0;
    last_col = (EW'(x_cur) == w_eff - EW'(1));
    last_row = (HREG_W'(y_cur) == h_eff - HREG_W'(1));
    big      = (w_eff >= EW'(3)) && (h_eff >= HREG_W'(3));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : y_cur + POSY_W'(1);
    end else begin
      col_nxt = x_cur + CNT_W'(1);
      row_nxt = y_cur;
    end
  end

  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_FRAME_WIDTH;
      frame_height_r <= RESET_FRAME_HEIGHT;
      thr_r          <= '0;
      col_r          <= '0;
      row_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wdata[WREG_W-1:0];
          col_r         <= '0;
          row_r         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata[HREG_W-1:0];
          col_r          <= '0;
          row_r          <= '0;
        end
        REG_SCORE_THRESHOLD: begin
          thr_r <= 32'($signed(cfg_wdata[SB-1:0]));
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------- line buffers
  // Upper half holds the row two above, lower half the row just above.
  smlm3_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata (wdata),
    .raddr (x_cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      // The write-back of the beat in flight lands on the same edge as this
      // read, so its data is taken from the bypass instead of the RAM.
      fwd_r      <= in_acc && s1_valid_r && (x_cur == s1_x_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wdata;
    if (in_acc) begin
      s1_x_r        <= x_cur;
      s1_y_r        <= y_cur;
      s1_score_r    <= 32'($signed(in_ch.score[SB-1:0]));
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
      s1_big_r      <= big;
      s1_end_r      <= last_col && last_row;
    end
    if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // ------------------------------------------------------------ window stage
  always_comb begin
    rd_word = fwd_r ? fwd_data_r : ram_rdata;
    rd_a    = 32'($signed(rd_word[SB-1:0]));
    rd_b    = 32'($signed(rd_word[2*SB-1:SB]));
    wdata   = {rd_word[SB-1:0], s1_score_r[SB-1:0]};

    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_b;
    win_nxt[1][2] = rd_a;
    win_nxt[2][2] = s1_score_r;

    rlo = (s1_y_r >= POSY_W'(2)) ? 0 : 1;
    clo = (s1_x_r >= CNT_W'(2)) ? 0 : 1;
    xm1 = s1_x_r - CNT_W'(1);
    ym1 = s1_y_r - POSY_W'(1);

    res_mask = '0;
    res_mask[SLOT_CENTER] = s1_big_r && (s1_x_r != '0) && (s1_y_r != '0)
                            && peak_at(win_nxt, 1, 1, rlo, clo, thr_r);
    res_mask[SLOT_RIGHT]  = s1_big_r && s1_last_col_r && (s1_y_r != '0)
                            && peak_at(win_nxt, 1, 2, rlo, 1, thr_r);
    res_mask[SLOT_BOTTOM] = s1_big_r && s1_last_row_r && (s1_x_r != '0)
                            && peak_at(win_nxt, 2, 1, 1, clo, thr_r);
    res_mask[SLOT_CORNER] = s1_big_r && s1_last_col_r && s1_last_row_r
                            && peak_at(win_nxt, 2, 2, 1, 1, thr_r);
    res_mask[SLOT_END]    = s1_end_r;

    res[SLOT_CENTER] = '{pos_x: POSX_W'(xm1), pos_y: ym1,
                         peak_score: win_nxt[1][1], frame_end: 1'b0};
    res[SLOT_RIGHT]  = '{pos_x: POSX_W'(s1_x_r), pos_y: ym1,
                         peak_score: win_nxt[1][2], frame_end: 1'b0};
    res[SLOT_BOTTOM] = '{pos_x: POSX_W'(xm1), pos_y: s1_y_r,
                         peak_score: win_nxt[2][1], frame_end: 1'b0};
    res[SLOT_CORNER] = '{pos_x: POSX_W'(s1_x_r), pos_y: s1_y_r,
                         peak_score: win_nxt[2][2], frame_end: 1'b0};
    res[SLOT_END]    = '{pos_x: '0, pos_y: '0, peak_score: '0, frame_end: 1'b1};
  end

  // ----------------------------------------------------------- result buffer
  always_comb begin
    b_pick = '0;
    b_sel  = b_rec_r[0];
    for (int i = N_RES - 1; i >= 0; i--) begin
      if (b_mask_r[i]) begin
        b_pick = '0;
        b_pick[i] = 1'b1;
        b_sel  = b_rec_r[i];
      end
    end
    b_load = s1_valid_r && (res_mask != '0);
    b_move = (b_mask_r != '0) && (!out_valid_r || out_ch.ready);
    if (b_load) begin
      b_mask_nxt = res_mask;
    end else if (b_move) begin
      b_mask_nxt = b_mask_r & ~b_pick;
    end else begin
      b_mask_nxt = b_mask_r;
    end
    // A new beat is taken only if its results will find the buffer empty.
    in_ready = !b_load && ((b_mask_r == '0) || ($onehot(b_mask_r) && b_move));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_mask_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_mask_r <= b_mask_nxt;
      if (b_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      for (int i = 0; i < N_RES; i++) begin
        b_rec_r[i] <= res[i];
      end
    end
    if (b_move) begin
      out_rec_r <= b_sel;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pos_x      = out_rec_r.pos_x;
  assign out_ch.pos_y      = out_rec_r.pos_y;
  assign out_ch.peak_score = out_rec_r.peak_score;
  assign out_ch.frame_end  = out_rec_r.frame_end;

  // -------------------------------------------------------------- assertions
  `SMLM3_ASSERT_IMP(a_load_into_empty, clk, rst_n, b_load, b_mask_r == '0)
  `SMLM3_ASSERT_NEXT(a_accept_leaves_room, clk, rst_n, in_acc, b_mask_r == '0)
  `SMLM3_ASSERT_IMP(a_fwd_needs_beat, clk, rst_n, fwd_r, s1_valid_r)
  `SMLM3_ASSERT_NEXT(a_move_fills_out, clk, rst_n, b_move, out_valid_r)
  `SMLM3_ASSERT_IMP(a_col_in_frame, clk, rst_n, 1'b1, EW'(col_r) < w_eff)

endmodule
